[src/line_rasterizer_with_clip_macros.svh]
// ----------------------------------------------------------------------------
// line rasterizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_WITH_CLIP_MACROS_SVH
`define LINE_RASTERIZER_WITH_CLIP_MACROS_SVH

// same-cycle implication
`define LRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// next-cycle implication
`define LRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

[src/lrc_pkg.sv]
// ----------------------------------------------------------------------------
// line rasterizer package
// item codes, register map and reset constants
// ----------------------------------------------------------------------------
package lrc_pkg;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        REG_VIEW_X_MIN = 2'd0,
        REG_VIEW_X_MAX = 2'd1,
        REG_VIEW_Y_MIN = 2'd2,
        REG_VIEW_Y_MAX = 2'd3
    } t_reg_idx;

    localparam int APB_ADDR_BITS    = 4;
    localparam int APB_DATA_BITS    = 32;
    localparam int COLOR_BITS       = 24;
    localparam int VIEW_X_MIN_RESET = 0;
    localparam int VIEW_X_MAX_RESET = 640;
    localparam int VIEW_Y_MIN_RESET = 0;
    localparam int VIEW_Y_MAX_RESET = 480;

endpackage

[src/lrc_ifs.sv]
// ----------------------------------------------------------------------------
// line rasterizer channels
// valid/ready interfaces for the line item and pixel result channels
// ----------------------------------------------------------------------------
interface lrc_in_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         crop_mode;
    logic [23:0]                  line_color;

    modport source (
        output valid, func, start_x, start_y, end_x, end_y, crop_mode, line_color,
        input  ready
    );
    modport sink (
        input  valid, func, start_x, start_y, end_x, end_y, crop_mode, line_color,
        output ready
    );
endinterface

interface lrc_out_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [23:0]                  pixel_color;
    logic                         line_done;

    modport source (
        output valid, pixel_valid, pixel_x, pixel_y, pixel_color, line_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, line_done,
        output ready
    );
endinterface

[src/line_rasterizer_with_clip.sv]
// ----------------------------------------------------------------------------
// line rasterizer with viewport crop
// steps a line one pixel per beat with an exact floor/remainder minor axis
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_line    in   valid/ready      func, endpoints, crop_mode, line_color
//  o_pixel   out  valid/ready      pixel_valid, pixel_x, pixel_y, pixel_color, line_done
//  apb       in   psel/penable     viewport bounds, 4-byte stride
//
//  one beat per cycle in unless a result is stalled, one result beat per item, registered
//  the minor-axis remainder add/compare is combinational
//  result reg decouples the sides; i_line.ready drops only in reset or while a result stalls
//  synchronous active-low reset clears the line state and the valid bit of the result register
// ----------------------------------------------------------------------------
module line_rasterizer_with_clip
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lrc_in_if.sink                   i_line,
    lrc_out_if.source                o_pixel,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int C = COORD_BITS;

    logic signed [C-1:0] w_vx_min, w_vx_max, w_vy_min, w_vy_max;

    lrc_cfg_regs #(.COORD_BITS(C)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_view_x_min (w_vx_min),
        .o_view_x_max (w_vx_max),
        .o_view_y_min (w_vy_min),
        .o_view_y_max (w_vy_max)
    );

    // line state
    logic                r_active, n_active;
    logic                r_steep, n_steep;
    logic                r_crop_on, n_crop_on;
    logic signed [C-1:0] r_major_pos, n_major_pos;
    logic signed [C-1:0] r_major_end, n_major_end;
    logic signed [C-1:0] r_minor_floor, n_minor_floor;
    logic [C-1:0]        r_minor_rem, n_minor_rem;
    logic [C-1:0]        r_major_span, n_major_span;
    logic signed [C:0]   r_minor_span, n_minor_span;
    logic [23:0]         r_color, n_color;

    // result register
    logic                r_out_valid, n_out_valid;
    logic                r_pix_valid, n_pix_valid;
    logic signed [C-1:0] r_pix_x, n_pix_x;
    logic signed [C-1:0] r_pix_y, n_pix_y;
    logic [23:0]         r_pix_color, n_pix_color;
    logic                r_line_done, n_line_done;

    logic accept;

    assign i_line.ready = i_rst_n && (!r_out_valid || o_pixel.ready);
    assign accept       = i_line.valid && i_line.ready;

    always_comb begin
        logic signed [C:0]   d_x, d_y, d_maj, d_min;
        logic [C-1:0]        abs_x, abs_y;
        logic                steep, swap;
        logic signed [C-1:0] m_a, m_b, n_a, n_b;
        logic signed [C-1:0] minor_now, px, py;
        logic                in_view, last;
        logic signed [C+1:0] rem_sum;

        // start path
        d_x   = $signed({i_line.end_x[C-1], i_line.end_x})
              - $signed({i_line.start_x[C-1], i_line.start_x});
        d_y   = $signed({i_line.end_y[C-1], i_line.end_y})
              - $signed({i_line.start_y[C-1], i_line.start_y});
        abs_x = d_x[C] ? C'(-d_x) : d_x[C-1:0];
        abs_y = d_y[C] ? C'(-d_y) : d_y[C-1:0];
        steep = abs_x < abs_y;
        d_maj = steep ? d_y : d_x;
        d_min = steep ? d_x : d_y;
        swap  = d_maj[C];
        m_a   = steep ? i_line.start_y : i_line.start_x;
        m_b   = steep ? i_line.end_y   : i_line.end_x;
        n_a   = steep ? i_line.start_x : i_line.start_y;
        n_b   = steep ? i_line.end_x   : i_line.end_y;

        // step path
        minor_now = (r_minor_floor < 0 && r_minor_rem != '0) ? r_minor_floor + C'(1)
                                                             : r_minor_floor;
        px        = r_steep ? minor_now : r_major_pos;
        py        = r_steep ? r_major_pos : minor_now;
        in_view   = px > w_vx_min && px < w_vx_max && py > w_vy_min && py < w_vy_max;
        last      = r_major_pos >= r_major_end;
        rem_sum   = $signed({2'b00, r_minor_rem})
                  + $signed({r_minor_span[C], r_minor_span});

        n_active      = r_active;
        n_steep       = r_steep;
        n_crop_on     = r_crop_on;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_floor = r_minor_floor;
        n_minor_rem   = r_minor_rem;
        n_major_span  = r_major_span;
        n_minor_span  = r_minor_span;
        n_color       = r_color;

        n_out_valid = r_out_valid;
        n_pix_valid = r_pix_valid;
        n_pix_x     = r_pix_x;
        n_pix_y     = r_pix_y;
        n_pix_color = r_pix_color;
        n_line_done = r_line_done;

        if (o_pixel.ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            n_out_valid = 1'b1;
            n_pix_valid = 1'b0;
            n_pix_x     = '0;
            n_pix_y     = '0;
            n_pix_color = '0;
            n_line_done = 1'b0;
            if (i_line.func == FUNC_START) begin
                n_active      = 1'b1;
                n_steep       = steep;
                n_crop_on     = i_line.crop_mode;
                n_major_pos   = swap ? m_b : m_a;
                n_major_end   = swap ? m_a : m_b;
                n_minor_floor = swap ? n_b : n_a;
                n_minor_rem   = '0;
                n_major_span  = steep ? abs_y : abs_x;
                n_minor_span  = swap ? -d_min : d_min;
                n_color       = i_line.line_color;
            end else if (!r_active) begin
                n_line_done = 1'b1;
            end else begin
                n_pix_valid = !r_crop_on || in_view;
                n_pix_x     = px;
                n_pix_y     = py;
                n_pix_color = r_color;
                if (last) begin
                    n_line_done = 1'b1;
                    n_active    = 1'b0;
                end else begin
                    n_major_pos = r_major_pos + C'(1);
                    if (!r_minor_span[C]) begin
                        if (rem_sum >= $signed({2'b00, r_major_span})) begin
                            n_minor_rem   = C'(rem_sum - $signed({2'b00, r_major_span}));
                            n_minor_floor = r_minor_floor + C'(1);
                        end else begin
                            n_minor_rem = rem_sum[C-1:0];
                        end
                    end else begin
                        if (rem_sum[C+1]) begin
                            n_minor_rem   = C'(rem_sum + $signed({2'b00, r_major_span}));
                            n_minor_floor = r_minor_floor - C'(1);
                        end else begin
                            n_minor_rem = rem_sum[C-1:0];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_steep       <= 1'b0;
            r_crop_on     <= 1'b0;
            r_major_pos   <= '0;
            r_major_end   <= '0;
            r_minor_floor <= '0;
            r_minor_rem   <= '0;
            r_major_span  <= '0;
            r_minor_span  <= '0;
            r_color       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_active      <= n_active;
            r_steep       <= n_steep;
            r_crop_on     <= n_crop_on;
            r_major_pos   <= n_major_pos;
            r_major_end   <= n_major_end;
            r_minor_floor <= n_minor_floor;
            r_minor_rem   <= n_minor_rem;
            r_major_span  <= n_major_span;
            r_minor_span  <= n_minor_span;
            r_color       <= n_color;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_valid <= n_pix_valid;
        r_pix_x     <= n_pix_x;
        r_pix_y     <= n_pix_y;
        r_pix_color <= n_pix_color;
        r_line_done <= n_line_done;
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_valid = r_pix_valid;
    assign o_pixel.pixel_x     = r_pix_x;
    assign o_pixel.pixel_y     = r_pix_y;
    assign o_pixel.pixel_color = r_pix_color;
    assign o_pixel.line_done   = r_line_done;

endmodule

[src/lrc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// line rasterizer viewport registers
// apb register file holding the four exclusive crop bounds
// ----------------------------------------------------------------------------
module lrc_cfg_regs
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_BITS-1:0]     paddr,
    input  logic [APB_DATA_BITS-1:0]     pwdata,
    output logic [APB_DATA_BITS-1:0]     prdata,
    output logic                         pready,
    output logic signed [COORD_BITS-1:0] o_view_x_min,
    output logic signed [COORD_BITS-1:0] o_view_x_max,
    output logic signed [COORD_BITS-1:0] o_view_y_min,
    output logic signed [COORD_BITS-1:0] o_view_y_max
);

    logic signed [COORD_BITS-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic signed [COORD_BITS-1:0] w_data;
    logic                         w_wr;
    t_reg_idx                     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_data = pwdata[COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= COORD_BITS'(VIEW_X_MIN_RESET);
            r_x_max <= COORD_BITS'(VIEW_X_MAX_RESET);
            r_y_min <= COORD_BITS'(VIEW_Y_MIN_RESET);
            r_y_max <= COORD_BITS'(VIEW_Y_MAX_RESET);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_VIEW_X_MIN: r_x_min <= w_data;
                REG_VIEW_X_MAX: r_x_max <= w_data;
                REG_VIEW_Y_MIN: r_y_min <= w_data;
                REG_VIEW_Y_MAX: r_y_max <= w_data;
                default:        r_x_min <= r_x_min;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_VIEW_X_MIN: prdata = APB_DATA_BITS'(r_x_min);
            REG_VIEW_X_MAX: prdata = APB_DATA_BITS'(r_x_max);
            REG_VIEW_Y_MIN: prdata = APB_DATA_BITS'(r_y_min);
            REG_VIEW_Y_MAX: prdata = APB_DATA_BITS'(r_y_max);
            default:        prdata = '0;
        endcase
    end

    assign o_view_x_min = r_x_min;
    assign o_view_x_max = r_x_max;
    assign o_view_y_min = r_y_min;
    assign o_view_y_max = r_y_max;

endmodule

[src/lrc_checker.sv]
// ----------------------------------------------------------------------------
// line rasterizer port checker
// port-level properties, bound to the top level
// ----------------------------------------------------------------------------
`include "line_rasterizer_with_clip_macros.svh"

module lrc_checker
    import lrc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_func,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_pixel_valid,
    input logic signed [COORD_BITS-1:0] out_pixel_x,
    input logic signed [COORD_BITS-1:0] out_pixel_y,
    input logic [23:0]                  out_pixel_color,
    input logic                         out_line_done
);

    logic start_beat;
    logic blank_reply;

    assign start_beat  = in_valid && in_ready && in_func == FUNC_START;
    assign blank_reply = !out_pixel_valid && !out_line_done && out_pixel_x == '0
                         && out_pixel_y == '0 && out_pixel_color == '0;

    `LRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `LRC_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
    `LRC_ASSERT_NEXT(a_beat_per_item, in_valid && in_ready, out_valid)
    `LRC_ASSERT_NEXT(a_start_reply, start_beat, blank_reply)

endmodule

bind line_rasterizer_with_clip lrc_checker #(.COORD_BITS(COORD_BITS)) u_lrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .in_valid        (i_line.valid),
    .in_ready        (i_line.ready),
    .in_func         (i_line.func),
    .out_valid       (o_pixel.valid),
    .out_ready       (o_pixel.ready),
    .out_pixel_valid (o_pixel.pixel_valid),
    .out_pixel_x     (o_pixel.pixel_x),
    .out_pixel_y     (o_pixel.pixel_y),
    .out_pixel_color (o_pixel.pixel_color),
    .out_line_done   (o_pixel.line_done)
);
